/* rtl/core/tmb_pkg.sv */
// Shared types and codes for the timer bank: command codes, result codes,
// the packed slot record kept in the slot RAM and the slot ALU result.
// No dependencies.
package tmb_pkg;

    localparam int TAG_W  = 31;
    localparam int TIME_W = 32;

    typedef enum logic [2:0] {
        CMD_START_ONCE = 3'd0,
        CMD_START_REP  = 3'd1,
        CMD_CANCEL     = 3'd2,
        CMD_CANCEL_ALL = 3'd3,
        CMD_TICK       = 3'd4
    } t_cmd;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] elapsed;
        logic              rpt;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic              fire;
        logic              keep;
        logic              tag_hit;
        logic [TIME_W-1:0] elapsed;
    } t_alu_res;

endpackage

/* rtl/core/tmb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/tmb_slot_alu.sv */
// Shared slot unit: saturating elapsed-time add, fire compare, id compare.
// Depends on tmb_pkg.
module tmb_slot_alu (
    input  tmb_pkg::t_slot                  i_slot,
    input  logic [tmb_pkg::TIME_W-1:0]      i_delta,
    input  logic [tmb_pkg::TAG_W-1:0]       i_target,
    output tmb_pkg::t_alu_res               o_res
);
    import tmb_pkg::*;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat;
    logic              fire;

    always_comb begin
        sum  = {1'b0, i_slot.elapsed} + {1'b0, i_delta};
        // saturate on carry out
        sat  = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        fire = (sat >= i_slot.delay);
        o_res.fire    = fire;
        o_res.keep    = !fire || i_slot.rpt;
        o_res.tag_hit = (i_slot.tag == i_target);
        o_res.elapsed = (fire && i_slot.rpt) ? {TIME_W{1'b0}} : sat;
    end
endmodule

/* rtl/core/timer_bank_once_and_periodic_unit.sv */
// Top level of the timer bank: request sequencer, live bits, output register.
// Depends on tmb_pkg, tmb_ram and tmb_slot_alu.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (start
//   once, start repeating, cancel by id, cancel all, tick), tdata carries
//   delay_us, target_id and delta_us. Results leave on m_axis: tuser is the
//   kind (acknowledge or fire), tdata holds timer_tag and status, tlast marks
//   the final result of a request.
//   A start puts its one result on m_axis from the start state once the
//   output register is free. A cancel by id walks the slot list. Cancel
//   all and unused commands finish in the idle state and give no result.
//   A tick walks every used slot through the shared slot ALU at one slot
//   per cycle while the output is not stalled, reading each slot from the
//   single-port-read slot RAM and writing survivors back compacted.
//   s_axis_tready is high only while no request is in progress.
//   When the receiver stalls, the output register holds its result and the
//   walk pauses at the next slot that fires; nothing is dropped.
//   Reset (synchronous, active low) empties the bank and sets the next id
//   to one; slot RAM contents need no clearing.
module timer_bank_once_and_periodic_unit #(
    parameter int MAX_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // delay_us[31:0], target_id[62:32], delta_us[94:63], pad
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // timer_tag[30:0], status[31]
    output logic        m_axis_tuser,  // kind[0]
    output logic        m_axis_tlast
);
    import tmb_pkg::*;

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TIMERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CANCEL,
        S_TICK,
        S_FLUSH
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [TIME_W-1:0]    r_delay;
    logic [TAG_W-1:0]     r_target;
    logic [TIME_W-1:0]    r_delta;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_wcnt;
    logic [CNT_W-1:0]     r_used;
    logic [MAX_TIMERS-1:0] r_live;
    logic [TAG_W-1:0]     r_next_tag;
    logic                 r_pend_valid;
    logic [TAG_W-1:0]     r_pend_tag;
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [TAG_W-1:0]     r_out_tag;
    logic                 r_out_status;
    logic                 r_out_last;

    t_slot                rd_slot;
    t_slot                wr_slot;
    logic [SLOT_W-1:0]    rd_word;
    t_alu_res             alu;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic                 out_free;
    logic                 live_i;
    logic                 is_last;
    logic                 tick_stall;
    logic                 tick_adv;
    logic                 tick_keep;
    logic [CNT_W-1:0]     n_wcnt;
    logic                 start_ok;

    assign rd_slot = t_slot'(rd_word);

    tmb_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_slot),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    tmb_slot_alu u_alu (
        .i_slot   (rd_slot),
        .i_delta  (r_delta),
        .i_target (r_target),
        .o_res    (alu)
    );

    always_comb begin
        out_free   = !r_out_valid || m_axis_tready;
        live_i     = r_live[r_idx];
        is_last    = ((CNT_W'(r_idx) + CNT_W'(1)) == r_used);
        tick_stall = live_i && alu.fire && r_pend_valid && !out_free;
        tick_adv   = (r_state == S_TICK) && !tick_stall;
        tick_keep  = live_i && alu.keep;
        n_wcnt     = r_wcnt + (tick_keep ? CNT_W'(1) : CNT_W'(0));
        start_ok   = (r_used != FULL_CNT);

        ram_we    = 1'b0;
        ram_waddr = r_wcnt[IDX_W-1:0];
        wr_slot   = rd_slot;
        wr_slot.elapsed = alu.elapsed;
        ram_raddr = '0;
        case (r_state)
            S_START: begin
                ram_we          = out_free && start_ok;
                ram_waddr       = r_used[IDX_W-1:0];
                wr_slot.tag     = r_next_tag;
                wr_slot.delay   = r_delay;
                wr_slot.elapsed = '0;
                wr_slot.rpt     = (r_cmd == CMD_START_REP);
            end
            S_CANCEL: begin
                ram_raddr = r_idx + IDX_W'(1);
            end
            S_TICK: begin
                ram_we    = tick_adv && tick_keep;
                // re-read the same slot while stalled
                ram_raddr = tick_adv ? (r_idx + IDX_W'(1)) : r_idx;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_live       <= '0;
            r_next_tag   <= TAG_W'(1);
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= t_cmd'(s_axis_tuser);
                        r_delay  <= s_axis_tdata[31:0];
                        r_target <= s_axis_tdata[62:32];
                        r_delta  <= s_axis_tdata[94:63];
                        r_idx    <= '0;
                        r_wcnt   <= '0;
                        case (t_cmd'(s_axis_tuser))
                            CMD_START_ONCE, CMD_START_REP: begin
                                r_state <= S_START;
                            end
                            CMD_CANCEL: begin
                                if (r_used != '0) begin
                                    r_state <= S_CANCEL;
                                end
                            end
                            CMD_CANCEL_ALL: begin
                                r_live <= '0;
                                r_used <= '0;
                            end
                            CMD_TICK: begin
                                if (r_used != '0) begin
                                    r_state      <= S_TICK;
                                    r_pend_valid <= 1'b0;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_START: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_ACK;
                        r_out_last  <= 1'b1;
                        if (start_ok) begin
                            r_out_tag             <= r_next_tag;
                            r_out_status          <= STAT_OK;
                            r_live[r_used[IDX_W-1:0]] <= 1'b1;
                            r_used                <= r_used + CNT_W'(1);
                            r_next_tag            <= r_next_tag + TAG_W'(1);
                        end else begin
                            r_out_tag    <= '0;
                            r_out_status <= STAT_FULL;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CANCEL: begin
                    if (alu.tag_hit) begin
                        r_live[r_idx] <= 1'b0;
                        r_state       <= S_IDLE;
                    end else if (is_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_TICK: begin
                    if (tick_adv) begin
                        if (live_i && alu.fire) begin
                            // hold this fire back until we know whether it is the final one
                            r_pend_tag   <= rd_slot.tag;
                            r_pend_valid <= 1'b1;
                            if (r_pend_valid) begin
                                r_out_valid  <= 1'b1;
                                r_out_kind   <= KIND_FIRE;
                                r_out_tag    <= r_pend_tag;
                                r_out_status <= STAT_OK;
                                r_out_last   <= 1'b0;
                            end
                        end
                        if (tick_keep) begin
                            r_live[r_wcnt[IDX_W-1:0]] <= 1'b1;
                        end
                        r_wcnt <= n_wcnt;
                        if (is_last) begin
                            for (int k = 0; k < MAX_TIMERS; k++) begin
                                if (CNT_W'(k) >= n_wcnt) begin
                                    r_live[k] <= 1'b0;
                                end
                            end
                            r_used  <= n_wcnt;
                            r_state <= S_FLUSH;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_FIRE;
                        r_out_tag    <= r_pend_tag;
                        r_out_status <= STAT_OK;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_tag};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("slot count above bank size");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_wcnt <= CNT_W'(r_idx)))
        else $error("compaction write index overtook read index");

    a_start_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START && out_free && start_ok)
        |=> (r_used == $past(r_used) + CNT_W'(1)) && r_out_valid)
        else $error("accepted start did not occupy a slot");

    a_flush_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && r_pend_valid && out_free)
        |=> r_out_valid && r_out_last && (r_out_kind == KIND_FIRE))
        else $error("final fire not marked last");
endmodule
